// ----- hw/rtl/wed_pkg.sv -----
package wed_pkg;

    // field and datapath widths
    localparam int SYM_W    = 6;
    localparam int COST_W   = 3;
    localparam int CELL_W   = 11;
    localparam int SCORE_W  = 17;
    localparam int COL_W    = 3;
    localparam int SUM_W    = 12;
    localparam int SAT_IN_W = 20;
    localparam int DIV_W    = 16;
    localparam int IDX_W    = 2;

    localparam int CELL_MAX    = 2047;
    localparam int SCORE_SCALE = 25;

    // opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_ADJACENT = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MISMATCH = 2'd1;
    localparam logic [IDX_W-1:0] CFG_GAP      = 2'd2;

    typedef logic [CELL_W-1:0] t_cell;

    typedef struct packed {
        logic [COST_W-1:0] adjacent;
        logic [COST_W-1:0] mismatch;
        logic [COST_W-1:0] gap;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic sweep_step;
        logic fin_load;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic qlen_full;
        logic sweep_done;
        logic div_done;
        logic out_free;
    } t_sts;

    // clamp a wide non-negative value to the cell range
    function automatic t_cell f_sat(input logic [SAT_IN_W-1:0] v);
        if (v > SAT_IN_W'(CELL_MAX)) begin
            return t_cell'(CELL_MAX);
        end
        return v[CELL_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/weighted_edit_distance.sv -----
// clear and append update the strings when accepted; a query symbol sweeps a
// reference of n symbols, one row-memory read per cell
// finish: reads the last row cell and runs the 16-step score divider, then loads
// the result beat; the next item is accepted while a result beat waits
// reset (synchronous, active low) empties both strings, clears the overflow
// flag and loads cost registers 1, 4, 4; the memories are not cleared
module weighted_edit_distance
    import wed_pkg::*;
#(
    parameter int MAX_LENGTH   = 64,
    parameter int GRID_COLUMNS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [SYM_W-1:0]   i_symbol,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [CELL_W-1:0]  o_distance_quarters,
    output logic [SCORE_W-1:0] o_score,
    output logic               o_length_overflow,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [COST_W-1:0]  i_cfg_data
);

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    // cost registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.adjacent <= COST_W'(1);
            r_cfg.mismatch <= COST_W'(4);
            r_cfg.gap      <= COST_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ADJACENT: r_cfg.adjacent <= i_cfg_data;
                CFG_MISMATCH: r_cfg.mismatch <= i_cfg_data;
                CFG_GAP:      r_cfg.gap      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    wed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wed_dp #(
        .MAX_LENGTH   (MAX_LENGTH),
        .GRID_COLUMNS (GRID_COLUMNS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_cfg               (r_cfg),
        .i_opcode            (i_opcode),
        .i_symbol            (i_symbol),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_distance_quarters (o_distance_quarters),
        .o_score             (o_score),
        .o_length_overflow   (o_length_overflow)
    );

endmodule

// ----- hw/rtl/wed_div.sv -----
module wed_div
    import wed_pkg::*;
#(
    parameter int DEN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic [DIV_W-1:0] o_quotient,
    output logic             o_done
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DIV_W-1:0] r_quo;

    logic [DEN_W:0]   w_rem_sh;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // one restoring step: shift in next dividend bit, try subtract
    always_comb begin
        w_rem_sh = {r_rem, r_quo[DIV_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_den});
        w_diff   = w_rem_sh - {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = !r_busy;

endmodule

// ----- hw/rtl/wed_dp.sv -----
module wed_dp
    import wed_pkg::*;
#(
    parameter int MAX_LENGTH   = 64,
    parameter int GRID_COLUMNS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  t_cfg               i_cfg,
    input  logic [1:0]         i_opcode,
    input  logic [SYM_W-1:0]   i_symbol,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [CELL_W-1:0]  o_distance_quarters,
    output logic [SCORE_W-1:0] o_score,
    output logic               o_length_overflow
);

    localparam int AW     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int LW     = $clog2(MAX_LENGTH + 1);
    localparam int NSYM   = 2 ** SYM_W;

    // length and flag state
    logic [LW-1:0]      r_ref_len;
    logic [LW-1:0]      r_qlen;
    logic               r_ovf;

    // sweep state
    logic [LW-1:0]      r_cnt;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_addr;
    logic               r_fresh;
    logic [SYM_W-1:0]   r_sym;
    t_cell              r_diag;
    t_cell              r_left;
    t_cell              r_row0;

    // memories and registered read data
    t_cell              r_row_mem [MAX_LENGTH];
    logic [SYM_W-1:0]   r_ref_mem [MAX_LENGTH];
    t_cell              r_row_q;
    logic [SYM_W-1:0]   r_ref_q;

    // finish state
    t_cell              r_dist;
    logic               r_ovf_fin;
    logic               r_short_zero;

    // output register
    logic               r_out_valid;
    t_cell              r_dist_out;
    logic [SCORE_W-1:0] r_score_out;
    logic               r_ovf_out;

    logic [SYM_W-1:0]   w_row_tab [NSYM];
    logic [COL_W-1:0]   w_col_tab [NSYM];

    logic               w_is_append;
    logic               w_is_query;
    logic               w_append;
    logic               w_start;
    logic               w_issue;
    logic [AW-1:0]      w_rd_addr;
    logic [LW-1:0]      w_last;
    logic [LW-1:0]      w_qnext;
    t_cell              w_row0_next;
    logic [LW-1:0]      w_j;
    t_cell              w_above;
    logic [COST_W-1:0]  w_sub;
    logic               w_adj;
    logic [SYM_W-1:0]   w_ra;
    logic [SYM_W-1:0]   w_rb;
    logic [COL_W-1:0]   w_ca;
    logic [COL_W-1:0]   w_cb;
    logic [SUM_W-1:0]   w_up;
    logic [SUM_W-1:0]   w_lf;
    logic [SUM_W-1:0]   w_dg;
    logic [SUM_W-1:0]   w_best;
    t_cell              w_cell;
    logic [LW-1:0]      w_short;
    t_cell              w_dist;
    logic [DIV_W-1:0]   w_dividend;
    logic [DIV_W-1:0]   w_quot;
    logic               w_div_done;

    // symbol to grid row and column
    for (genvar gi = 0; gi < NSYM; gi++) begin : g_tab
        assign w_row_tab[gi] = SYM_W'(gi / GRID_COLUMNS);
        assign w_col_tab[gi] = COL_W'(gi % GRID_COLUMNS);
    end

    // accept decode
    always_comb begin
        w_is_append = i_cmd.accept && (i_opcode == OP_APPEND);
        w_is_query  = i_cmd.accept && (i_opcode == OP_QUERY);
        w_append    = w_is_append && (r_ref_len < LW'(MAX_LENGTH));
        w_start     = w_is_query && (r_qlen < LW'(MAX_LENGTH));
        w_qnext     = r_qlen + 1'b1;
        w_row0_next = f_sat(SAT_IN_W'(w_qnext) * SAT_IN_W'(i_cfg.gap));
    end

    // read address: sweep counter, else last reference cell for finish
    always_comb begin
        w_issue   = i_cmd.sweep_step && (r_cnt < r_ref_len);
        w_last    = r_ref_len - 1'b1;
        w_rd_addr = i_cmd.sweep_step ? r_cnt[AW-1:0] : w_last[AW-1:0];
    end

    // substitution cost
    always_comb begin
        w_ra  = w_row_tab[r_sym];
        w_rb  = w_row_tab[r_ref_q];
        w_ca  = w_col_tab[r_sym];
        w_cb  = w_col_tab[r_ref_q];
        w_adj = ((w_ra == w_rb) &&
                 (({1'b0, w_ca} + 1'b1 == {1'b0, w_cb}) ||
                  ({1'b0, w_cb} + 1'b1 == {1'b0, w_ca}))) ||
                ((w_ca == w_cb) &&
                 (({1'b0, w_ra} + 1'b1 == {1'b0, w_rb}) ||
                  ({1'b0, w_rb} + 1'b1 == {1'b0, w_ra})));
        if (r_sym == r_ref_q) begin
            w_sub = '0;
        end else if (w_adj) begin
            w_sub = i_cfg.adjacent;
        end else begin
            w_sub = i_cfg.mismatch;
        end
    end

    // one cell of the row update
    always_comb begin
        w_j     = LW'(r_rd_addr) + 1'b1;
        w_above = r_fresh ? f_sat(SAT_IN_W'(w_j) * SAT_IN_W'(i_cfg.gap)) : r_row_q;
        w_up    = SUM_W'(w_above) + SUM_W'(i_cfg.gap);
        w_lf    = SUM_W'(r_left) + SUM_W'(i_cfg.gap);
        w_dg    = SUM_W'(r_diag) + SUM_W'(w_sub);
        w_best  = w_up;
        if (w_lf < w_best) begin
            w_best = w_lf;
        end
        if (w_dg < w_best) begin
            w_best = w_dg;
        end
        w_cell = f_sat(SAT_IN_W'(w_best));
    end

    // finish: distance and divisor
    always_comb begin
        w_short = (r_qlen < r_ref_len) ? r_qlen : r_ref_len;
        if (r_qlen == '0) begin
            w_dist = f_sat(SAT_IN_W'(r_ref_len) * SAT_IN_W'(i_cfg.gap));
        end else if (r_ref_len == '0) begin
            w_dist = r_row0;
        end else begin
            w_dist = r_row_q;
        end
        w_dividend = DIV_W'(w_dist) * DIV_W'(SCORE_SCALE);
    end

    // lengths and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_len <= '0;
            r_qlen    <= '0;
            r_ovf     <= 1'b0;
        end else if (i_cmd.fin_load) begin
            r_qlen <= '0;
        end else if (i_cmd.accept) begin
            case (i_opcode)
                OP_CLEAR: begin
                    r_ref_len <= '0;
                    r_qlen    <= '0;
                    r_ovf     <= 1'b0;
                end
                OP_APPEND: begin
                    r_qlen <= '0;
                    if (w_append) begin
                        r_ref_len <= r_ref_len + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                OP_QUERY: begin
                    if (w_start) begin
                        r_qlen <= w_qnext;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else if (w_start) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
            if (w_issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // sweep payload
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_fresh <= (r_qlen == '0);
            r_sym   <= i_symbol;
            r_row0  <= w_row0_next;
            r_left  <= w_row0_next;
            r_diag  <= (r_qlen == '0) ? '0 : r_row0;
        end else if (r_rd_vld) begin
            r_diag <= w_above;
            r_left <= w_cell;
        end
        if (w_issue) begin
            r_rd_addr <= r_cnt[AW-1:0];
        end
    end

    // row and reference memories
    always_ff @(posedge i_clk) begin
        r_row_q <= r_row_mem[w_rd_addr];
        r_ref_q <= r_ref_mem[w_rd_addr];
        if (r_rd_vld) begin
            r_row_mem[r_rd_addr] <= w_cell;
        end
        if (w_append) begin
            r_ref_mem[r_ref_len[AW-1:0]] <= i_symbol;
        end
    end

    // finish capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_load) begin
            r_dist       <= w_dist;
            r_ovf_fin    <= r_ovf;
            r_short_zero <= (w_short == '0);
        end
    end

    wed_div #(
        .DEN_W (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.fin_load),
        .i_dividend (w_dividend),
        .i_divisor  (w_short),
        .o_quotient (w_quot),
        .o_done     (w_div_done)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_dist_out  <= r_dist;
            r_score_out <= r_short_zero ? SCORE_W'(r_dist) : SCORE_W'(w_quot);
            r_ovf_out   <= r_ovf_fin;
        end
    end

    // status
    always_comb begin
        o_sts.qlen_full  = (r_qlen >= LW'(MAX_LENGTH));
        o_sts.sweep_done = !w_issue && !r_rd_vld;
        o_sts.div_done   = w_div_done;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid         = r_out_valid;
    assign o_distance_quarters = r_dist_out;
    assign o_score             = r_score_out;
    assign o_length_overflow   = r_ovf_out;

    // lengths never pass the store depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ref_len <= LW'(MAX_LENGTH)) && (r_qlen <= LW'(MAX_LENGTH)))
        else $error("length beyond store depth");

    // row memory is written only by a sweep
    a_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(i_cmd.sweep_step))
        else $error("row write outside sweep");

    // sweep never reads past the reference
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sweep_step |-> (r_cnt <= r_ref_len))
        else $error("sweep counter beyond reference length");

    // divider runs after the finish load
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin_load |=> !o_sts.div_done)
        else $error("divider not started");

endmodule

// ----- hw/rtl/wed_ctrl.sv -----
module wed_ctrl
    import wed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_opcode,
    output logic       o_in_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SWEEP  = 5'b00010,
        S_FIN_RD = 5'b00100,
        S_DIV    = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd.accept     = w_accept;
        o_cmd.sweep_step = 1'b0;
        o_cmd.fin_load   = 1'b0;
        o_cmd.out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == OP_QUERY && !i_sts.qlen_full) begin
                        n_state = S_SWEEP;
                    end else if (i_opcode == OP_FINISH) begin
                        n_state = S_FIN_RD;
                    end
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            S_FIN_RD: begin
                o_cmd.fin_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- sim/wed_distance_checker.sv -----
module wed_distance_checker
    import wed_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [SYM_W-1:0]   i_symbol,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [CELL_W-1:0]  i_distance_quarters,
    input  logic [SCORE_W-1:0] i_score,
    input  logic               i_length_overflow,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [COST_W-1:0]  i_cfg_data,
    output int                 o_error_count,
    output int                 o_pending,
    output int                 o_results_checked,
    output int                 o_overflow_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN   = 64;
    localparam int GRID_COLS = 8;

    typedef struct {
        t_cell              distance;
        logic [SCORE_W-1:0] score;
        logic               overflow;
    } t_distance_result;

    t_distance_result  expected_distances[$];
    logic [SYM_W-1:0]  ref_string [MAX_LEN];
    t_cell             dp_row [MAX_LEN+1];
    int                ref_len;
    int                query_len;
    logic              overflow_flag;
    logic [COST_W-1:0] adjacent_cost;
    logic [COST_W-1:0] mismatch_cost;
    logic [COST_W-1:0] gap_cost;
    int                mismatch_total = 0;
    int                results_total  = 0;
    int                overflow_total = 0;

    assign o_error_count      = mismatch_total;
    assign o_results_checked  = results_total;
    assign o_overflow_results = overflow_total;

    // cells top out at the largest 11-bit value
    function automatic t_cell clamp_cell(input int v);
        return (v > CELL_MAX) ? t_cell'(CELL_MAX) : t_cell'(v);
    endfunction

    // substitution cost from grid positions
    function automatic int pair_cost(input logic [SYM_W-1:0] a, input logic [SYM_W-1:0] b);
        int ra, ca, rb, cb;
        if (a == b) begin
            return 0;
        end
        ra = a / GRID_COLS;
        ca = a % GRID_COLS;
        rb = b / GRID_COLS;
        cb = b % GRID_COLS;
        if ((ra == rb && (ca + 1 == cb || cb + 1 == ca)) ||
            (ca == cb && (ra + 1 == rb || rb + 1 == ra))) begin
            return adjacent_cost;
        end
        return mismatch_cost;
    endfunction

    // fold one accepted input beat into the alignment state
    function automatic void advance_alignment(input logic [1:0] op,
                                              input logic [SYM_W-1:0] sym);
        int diag, above, best, shorter;
        t_distance_result res;
        case (op)
            OP_CLEAR: begin
                ref_len       = 0;
                query_len     = 0;
                overflow_flag = 1'b0;
            end
            OP_APPEND: begin
                query_len = 0;
                if (ref_len < MAX_LEN) begin
                    ref_string[ref_len] = sym;
                    ref_len++;
                end else begin
                    overflow_flag = 1'b1;
                end
            end
            OP_QUERY: begin
                if (query_len >= MAX_LEN) begin
                    overflow_flag = 1'b1;
                end else begin
                    // first query symbol starts from the plain gap row
                    if (query_len == 0) begin
                        for (int j = 0; j <= MAX_LEN; j++) begin
                            dp_row[j] = clamp_cell(j * gap_cost);
                        end
                    end
                    query_len++;
                    diag      = dp_row[0];
                    dp_row[0] = clamp_cell(query_len * gap_cost);
                    for (int j = 1; j <= ref_len; j++) begin
                        above = dp_row[j];
                        best  = above + gap_cost;
                        if (int'(dp_row[j-1]) + gap_cost < best) begin
                            best = int'(dp_row[j-1]) + gap_cost;
                        end
                        if (diag + pair_cost(sym, ref_string[j-1]) < best) begin
                            best = diag + pair_cost(sym, ref_string[j-1]);
                        end
                        diag      = above;
                        dp_row[j] = clamp_cell(best);
                    end
                end
            end
            default: begin
                // finish: empty query falls back to the gap column
                if (query_len == 0) begin
                    res.distance = clamp_cell(ref_len * gap_cost);
                end else begin
                    res.distance = dp_row[ref_len];
                end
                shorter = (query_len < ref_len) ? query_len : ref_len;
                if (shorter == 0) begin
                    res.score = SCORE_W'(res.distance);
                end else begin
                    res.score = SCORE_W'(int'(res.distance) * SCORE_SCALE / shorter);
                end
                res.overflow = overflow_flag;
                expected_distances.push_back(res);
                query_len = 0;
            end
        endcase
    endfunction

    // compare one result beat with the oldest prediction
    function automatic void check_result();
        t_distance_result want;
        results_total++;
        if (i_length_overflow === 1'b1) begin
            overflow_total++;
        end
        if (expected_distances.size() == 0) begin
            if (mismatch_total < 10) begin
                $display("result %0d with nothing pending: dist %0d score %0d overflow %0b",
                         results_total, i_distance_quarters, i_score, i_length_overflow);
            end
            mismatch_total++;
            return;
        end
        want = expected_distances.pop_front();
        if (i_distance_quarters !== want.distance || i_score !== want.score ||
            i_length_overflow !== want.overflow) begin
            if (mismatch_total < 10) begin
                $display("result %0d mismatch: expected dist %0d score %0d overflow %0b",
                         results_total, want.distance, want.score, want.overflow);
                $display("    got dist %0d score %0d overflow %0b",
                         i_distance_quarters, i_score, i_length_overflow);
            end
            mismatch_total++;
        end
    endfunction

    // watch results, cost writes and input beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            adjacent_cost = 3'd1;
            mismatch_cost = 3'd4;
            gap_cost      = 3'd4;
            ref_len       = 0;
            query_len     = 0;
            overflow_flag = 1'b0;
            expected_distances.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ADJACENT: adjacent_cost = i_cfg_data;
                    CFG_MISMATCH: mismatch_cost = i_cfg_data;
                    CFG_GAP:      gap_cost      = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                advance_alignment(i_opcode, i_symbol);
            end
        end
        o_pending <= expected_distances.size();
    end

endmodule

// ----- sim/testbench.sv -----
module testbench;
    import wed_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 1_200_000;
    localparam int COST_PHASES     = 7;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int DRAIN_CYCLES    = 100;

    typedef enum int {
        SEQ_NORMAL,
        SEQ_LONG_REFERENCE,
        SEQ_LONG_QUERY,
        SEQ_FULL
    } t_seq_kind;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [1:0]         opcode    = OP_CLEAR;
    logic [SYM_W-1:0]   symbol    = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CELL_W-1:0]  distance_quarters;
    logic [SCORE_W-1:0] score;
    logic               length_overflow;
    logic               cfg_we    = 1'b0;
    logic [IDX_W-1:0]   cfg_index = CFG_ADJACENT;
    logic [COST_W-1:0]  cfg_data  = '0;

    logic [11:0]        ready_tick = '0;
    logic [SYM_W-1:0]   stored_syms[$];
    int                 cycle_count   = 0;
    int                 items_sent    = 0;
    int                 burst_left    = 0;
    int                 settings_used = 1;
    int                 phase_goal;
    int                 seq_in_phase;
    int                 error_count;
    int                 pending;
    int                 results_checked;
    int                 overflow_results;

    weighted_edit_distance i_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_opcode            (opcode),
        .i_symbol            (symbol),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_distance_quarters (distance_quarters),
        .o_score             (score),
        .o_length_overflow   (length_overflow),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    wed_distance_checker u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_ready          (in_ready),
        .i_opcode            (opcode),
        .i_symbol            (symbol),
        .i_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .i_distance_quarters (distance_quarters),
        .i_score             (score),
        .i_length_overflow   (length_overflow),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .o_error_count       (error_count),
        .o_pending           (pending),
        .o_results_checked   (results_checked),
        .o_overflow_results  (overflow_results)
    );

    // 100 MHz clock
    initial begin
        forever #5 clk = ~clk;
    end

    // result side stalls: always ready, coin flips, 1 in 8, long off stretches
    always @(posedge clk) begin
        ready_tick <= ready_tick + 12'd1;
        case (ready_tick[11:10])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 1) != 0);
            2'd2:    out_ready <= (ready_tick[2:0] == 3'd0);
            default: out_ready <= ~ready_tick[5];
        endcase
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // one input beat, with a random gap at the start of each burst
    task automatic push_item(input logic [1:0] op, input logic [SYM_W-1:0] sym);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                4, 5, 6, 7: gap = $urandom_range(1, 4);
                8:          gap = $urandom_range(5, 20);
                default:    gap = $urandom_range(21, 80);
            endcase
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode   <= op;
        symbol   <= sym;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // hold off until every pending distance has come back and the block is quiet
    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [COST_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // cost set for each phase, the last one random
    task automatic program_costs(input int phase);
        logic [COST_W-1:0] adj, mis, gap;
        case (phase)
            1: {adj, mis, gap} = {3'd0, 3'd0, 3'd0};
            2: {adj, mis, gap} = {3'd4, 3'd4, 3'd4};
            3: {adj, mis, gap} = {3'd2, 3'd3, 3'd1};
            4: {adj, mis, gap} = {3'd4, 3'd0, 3'd2};
            5: {adj, mis, gap} = {3'd1, 3'd2, 3'd0};
            default: begin
                adj = $urandom_range(0, 4);
                mis = $urandom_range(0, 4);
                gap = $urandom_range(0, 4);
            end
        endcase
        write_register(CFG_ADJACENT, adj);
        write_register(CFG_MISMATCH, mis);
        write_register(CFG_GAP, gap);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // grid neighbor, staying on the board
    function automatic logic [SYM_W-1:0] neighbour_of(input logic [SYM_W-1:0] s);
        logic [2:0] r, c;
        r = s[5:3];
        c = s[2:0];
        case ($urandom_range(0, 3))
            0:       c = (c == 3'd7) ? c - 3'd1 : c + 3'd1;
            1:       c = (c == 3'd0) ? c + 3'd1 : c - 3'd1;
            2:       r = (r == 3'd7) ? r - 3'd1 : r + 3'd1;
            default: r = (r == 3'd0) ? r + 3'd1 : r - 3'd1;
        endcase
        return {r, c};
    endfunction

    // query symbols lean toward equal, neighbor and row-wrap pairs
    function automatic logic [SYM_W-1:0] pick_query();
        int k;
        logic [SYM_W-1:0] s;
        k = $urandom_range(0, 9);
        if (stored_syms.size() == 0 || k >= 7) begin
            return SYM_W'($urandom);
        end
        s = stored_syms[$urandom_range(0, stored_syms.size() - 1)];
        if (k < 3) begin
            return s;
        end
        if (k < 6) begin
            return neighbour_of(s);
        end
        return ($urandom_range(0, 1) != 0) ? s + 6'd1 : s - 6'd1;
    endfunction

    function automatic t_seq_kind choose_kind(input int phase, input int seq);
        int k;
        if (phase == 0 && seq < 3) begin
            return t_seq_kind'(seq + 1);
        end
        if (phase == 2 && seq == 0) begin
            return SEQ_FULL;
        end
        k = $urandom_range(0, 99);
        if (k == 0) begin
            return SEQ_LONG_REFERENCE;
        end
        if (k == 1) begin
            return SEQ_LONG_QUERY;
        end
        return SEQ_NORMAL;
    endfunction

    // reference load followed by one or more query rounds, with occasional noise
    task automatic run_sequence(input t_seq_kind kind);
        int ref_count, query_count, rounds;
        logic [SYM_W-1:0] sym;
        if ($urandom_range(0, 24) == 0) begin
            drain_results();
        end
        if (kind != SEQ_NORMAL || $urandom_range(0, 9) < 7) begin
            push_item(OP_CLEAR, SYM_W'($urandom));
            stored_syms.delete();
        end
        case (kind)
            SEQ_LONG_REFERENCE: ref_count = $urandom_range(65, 68);
            SEQ_LONG_QUERY:     ref_count = $urandom_range(0, 6);
            SEQ_FULL:           ref_count = 64;
            default: ref_count = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24)
                                                             : $urandom_range(0, 10);
        endcase
        for (int i = 0; i < ref_count; i++) begin
            if (stored_syms.size() > 0 && $urandom_range(0, 1) != 0) begin
                sym = neighbour_of(stored_syms[$]);
            end else begin
                sym = SYM_W'($urandom);
            end
            stored_syms.push_back(sym);
            push_item(OP_APPEND, sym);
        end
        rounds = (kind == SEQ_NORMAL) ? $urandom_range(1, 3) : 1;
        repeat (rounds) begin
            case (kind)
                SEQ_LONG_REFERENCE: query_count = $urandom_range(0, 6);
                SEQ_LONG_QUERY:     query_count = $urandom_range(62, 70);
                SEQ_FULL:           query_count = 64;
                default:            query_count = $urandom_range(0, 10);
            endcase
            for (int i = 0; i < query_count; i++) begin
                push_item(OP_QUERY, pick_query());
                // broken sequences: append or clear mid-query, early finish
                if (kind == SEQ_NORMAL && $urandom_range(0, 39) == 0) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            sym = SYM_W'($urandom);
                            stored_syms.push_back(sym);
                            push_item(OP_APPEND, sym);
                        end
                        1: begin
                            push_item(OP_CLEAR, SYM_W'($urandom));
                            stored_syms.delete();
                        end
                        default: push_item(OP_FINISH, SYM_W'($urandom));
                    endcase
                end
            end
            if (kind != SEQ_NORMAL || $urandom_range(0, 19) != 0) begin
                push_item(OP_FINISH, SYM_W'($urandom));
            end
        end
    endtask

    // reset, directed cases, then random phases under several cost sets
    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // finish with both strings empty
        push_item(OP_FINISH, 6'd0);
        // empty reference, two query symbols at the symbol extremes
        push_item(OP_QUERY, 6'd0);
        push_item(OP_QUERY, 6'd63);
        push_item(OP_FINISH, 6'd63);
        // empty query against a one-symbol reference
        push_item(OP_APPEND, 6'd0);
        push_item(OP_FINISH, 6'd0);
        // equal, row neighbor, column neighbor, far mismatch
        push_item(OP_CLEAR, 6'd42);
        push_item(OP_APPEND, 6'd9);
        push_item(OP_QUERY, 6'd9);
        push_item(OP_FINISH, 6'd21);
        push_item(OP_QUERY, 6'd10);
        push_item(OP_FINISH, 6'd0);
        push_item(OP_QUERY, 6'd17);
        push_item(OP_FINISH, 6'd0);
        push_item(OP_QUERY, 6'd63);
        push_item(OP_FINISH, 6'd0);
        // consecutive codes across a row boundary are not neighbors
        push_item(OP_CLEAR, 6'd63);
        push_item(OP_APPEND, 6'd8);
        push_item(OP_QUERY, 6'd7);
        push_item(OP_FINISH, 6'd0);
        // append during a query restarts it
        push_item(OP_QUERY, 6'd1);
        push_item(OP_APPEND, 6'd63);
        push_item(OP_QUERY, 6'd63);
        push_item(OP_FINISH, 6'd0);
        // clear in the middle of a query
        push_item(OP_QUERY, 6'd5);
        push_item(OP_CLEAR, 6'd0);
        push_item(OP_FINISH, 6'd0);

        for (int phase = 0; phase < COST_PHASES; phase++) begin
            if (phase > 0) begin
                drain_results();
                program_costs(phase);
            end
            phase_goal   = items_sent + ITEMS_PER_PHASE;
            seq_in_phase = 0;
            while (items_sent < phase_goal) begin
                run_sequence(choose_kind(phase, seq_in_phase));
                seq_in_phase++;
            end
        end
        drain_results();

        $display("sent %0d input beats under %0d cost settings, checked %0d distance results",
                 items_sent, settings_used, results_checked);
        $display("%0d results carried the length overflow flag, %0d mismatches",
                 overflow_results, error_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/wed_pkg.sv
hw/rtl/wed_div.sv
hw/rtl/wed_dp.sv
hw/rtl/wed_ctrl.sv
hw/rtl/weighted_edit_distance.sv
sim/wed_distance_checker.sv
sim/testbench.sv
